[hw/rtl/fwd_pkg.sv]
// ----------------------------------------------------------------------------
// Word-delta decoder package
// Item types and shared constants of the word-delta chunk decoder.
// ----------------------------------------------------------------------------
package fwd_pkg;

  localparam logic [15:0] NEG_BIT  = 16'h8000;
  localparam logic [15:0] SKIP_BIT = 16'h4000;

  localparam logic [1:0] CFG_X_ORIGIN   = 2'd0;
  localparam logic [1:0] CFG_Y_ORIGIN   = 2'd1;
  localparam logic [1:0] CFG_LINE_WIDTH = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_start;
  } fwd_in_t;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [8:0]  span_length;
    logic [7:0]  even_pixel;
    logic [7:0]  odd_pixel;
    logic        chunk_done;
  } fwd_out_t;

  typedef struct packed {
    logic [15:0] x_origin;
    logic [15:0] y_origin;
    logic [15:0] line_width;
  } fwd_cfg_t;

endpackage

[hw/rtl/fwd_parser.sv]
// ----------------------------------------------------------------------------
// Word-delta chunk parser
// Byte-at-a-time parser state and the write, if any, that each byte produces.
// ----------------------------------------------------------------------------
module fwd_parser import fwd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  fwd_in_t  in_item,
  input  fwd_cfg_t cfg,
  output logic     res_valid,
  output fwd_out_t res_item
);

  localparam logic [3:0] PH_CNT_LO = 4'd0;
  localparam logic [3:0] PH_CNT_HI = 4'd1;
  localparam logic [3:0] PH_OP_LO  = 4'd2;
  localparam logic [3:0] PH_OP_HI  = 4'd3;
  localparam logic [3:0] PH_PC_LO  = 4'd4;
  localparam logic [3:0] PH_PC_HI  = 4'd5;
  localparam logic [3:0] PH_SKIP   = 4'd6;
  localparam logic [3:0] PH_SIZE   = 4'd7;
  localparam logic [3:0] PH_LIT    = 4'd8;
  localparam logic [3:0] PH_RUN0   = 4'd9;
  localparam logic [3:0] PH_RUN1   = 4'd10;
  localparam logic [3:0] PH_IDLE   = 4'd11;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] lines_left_r, lines_left_nxt;
  logic [15:0] packets_left_r, packets_left_nxt;
  logic [15:0] cur_col_r, cur_col_nxt;
  logic [15:0] cur_row_r, cur_row_nxt;
  logic [7:0]  literal_left_r, literal_left_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic [7:0]  run_words_r, run_words_nxt;

  logic [3:0]  phase;
  logic [7:0]  b;
  logic [15:0] w;
  logic [15:0] pk_dec;
  logic [15:0] lines_dec;
  logic [8:0]  run_span;
  logic        last_line;
  logic        start_pk;
  logic        pkt_end;
  logic        line_end;

  always_comb begin
    b         = in_item.data_byte;
    phase     = in_item.chunk_start ? PH_CNT_LO : phase_r;
    last_line = (lines_left_r == 16'd1);
    pk_dec    = packets_left_r - 16'd1;
    lines_dec = lines_left_r - 16'd1;
    run_span  = {run_words_r, 1'b0};

    phase_nxt        = phase;
    lines_left_nxt   = lines_left_r;
    packets_left_nxt = packets_left_r;
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    literal_left_nxt = literal_left_r;
    held_byte_nxt    = held_byte_r;
    run_words_nxt    = run_words_r;
    start_pk         = 1'b0;
    pkt_end          = 1'b0;
    line_end         = 1'b0;
    w                = 16'd0;

    res_valid = 1'b0;
    res_item  = '{col: cur_col_r, row: cur_row_r, span_length: 9'd1,
                  even_pixel: b, odd_pixel: b, chunk_done: 1'b0};

    case (phase)
      PH_CNT_LO: begin
        lines_left_nxt = {8'd0, b};
        phase_nxt      = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        lines_left_nxt = {b, lines_left_r[7:0]};
        cur_row_nxt    = cfg.y_origin;
        phase_nxt      = ({b, lines_left_r[7:0]} == 16'd0) ? PH_IDLE : PH_OP_LO;
      end
      PH_OP_LO: begin
        held_byte_nxt = b;
        phase_nxt     = PH_OP_HI;
      end
      PH_OP_HI: begin
        w = {b, held_byte_r};
        if ((w & NEG_BIT) == 16'd0) begin
          start_pk = 1'b1;
        end else if ((w & SKIP_BIT) != 16'd0) begin
          cur_row_nxt = cur_row_r - w;
          phase_nxt   = PH_OP_LO;
        end else begin
          phase_nxt = PH_PC_LO;
        end
      end
      PH_PC_LO: begin
        packets_left_nxt = {8'd0, b};
        phase_nxt        = PH_PC_HI;
      end
      PH_PC_HI: begin
        w         = {b, packets_left_r[7:0]};
        res_valid = 1'b1;
        res_item  = '{col: cfg.x_origin + cfg.line_width - 16'd1, row: cur_row_r,
                      span_length: 9'd1, even_pixel: held_byte_r,
                      odd_pixel: held_byte_r, chunk_done: (w == 16'd0) && last_line};
        start_pk  = 1'b1;
      end
      PH_SKIP: begin
        cur_col_nxt = cur_col_r + {8'd0, b};
        phase_nxt   = PH_SIZE;
      end
      PH_SIZE: begin
        if (!b[7]) begin
          literal_left_nxt = {b[6:0], 1'b0};
          if (b == 8'd0) begin
            pkt_end = 1'b1;
          end else begin
            phase_nxt = PH_LIT;
          end
        end else begin
          run_words_nxt = 8'd0 - b;
          phase_nxt     = PH_RUN0;
        end
      end
      PH_LIT: begin
        res_valid        = 1'b1;
        res_item.chunk_done = last_line && (packets_left_r == 16'd1) &&
                              (literal_left_r == 8'd1);
        cur_col_nxt      = cur_col_r + 16'd1;
        literal_left_nxt = literal_left_r - 8'd1;
        if (literal_left_r == 8'd1) begin
          pkt_end = 1'b1;
        end
      end
      PH_RUN0: begin
        held_byte_nxt = b;
        phase_nxt     = PH_RUN1;
      end
      PH_RUN1: begin
        res_valid   = 1'b1;
        res_item    = '{col: cur_col_r, row: cur_row_r, span_length: run_span,
                        even_pixel: held_byte_r, odd_pixel: b,
                        chunk_done: last_line && (packets_left_r == 16'd1)};
        cur_col_nxt = cur_col_r + {7'd0, run_span};
        pkt_end     = 1'b1;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (start_pk) begin
      packets_left_nxt = w;
      cur_col_nxt      = cfg.x_origin;
      if (w == 16'd0) begin
        line_end = 1'b1;
      end else begin
        phase_nxt = PH_SKIP;
      end
    end
    if (pkt_end) begin
      packets_left_nxt = pk_dec;
      if (pk_dec == 16'd0) begin
        line_end = 1'b1;
      end else begin
        phase_nxt = PH_SKIP;
      end
    end
    if (line_end) begin
      cur_row_nxt    = cur_row_r + 16'd1;
      lines_left_nxt = lines_dec;
      phase_nxt      = (lines_dec == 16'd0) ? PH_IDLE : PH_OP_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_CNT_LO;
      lines_left_r   <= '0;
      packets_left_r <= '0;
      cur_col_r      <= '0;
      cur_row_r      <= '0;
      literal_left_r <= '0;
      held_byte_r    <= '0;
      run_words_r    <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      lines_left_r   <= lines_left_nxt;
      packets_left_r <= packets_left_nxt;
      cur_col_r      <= cur_col_nxt;
      cur_row_r      <= cur_row_nxt;
      literal_left_r <= literal_left_nxt;
      held_byte_r    <= held_byte_nxt;
      run_words_r    <= run_words_nxt;
    end
  end

endmodule

[hw/rtl/flc_word_delta_decoder_unit.sv]
// ----------------------------------------------------------------------------
// Word-delta chunk decoder
// Turns a word-delta frame chunk, one byte per item, into pixel and span
// writes for a frame buffer.
//
// The input channel takes one compressed byte per item; chunk_start on the
// first byte restarts the parser. The result channel gives at most one write
// per input item. The configuration channel sets the rectangle origin and
// width; it is always ready, and the user must write it only while the
// decoder is idle; the block does not enforce this. A byte is parsed in the
// cycle it is accepted and its write is registered. The sustained rate is
// one byte per cycle while in_ready is high, set by the single parser pass.
// When the receiver stalls, one further write is held in a skid register;
// in_ready drops only while that skid register is full.
// Synchronous reset restores the rectangle defaults, returns the parser to
// waiting for a line count and empties both output registers.
// ----------------------------------------------------------------------------
module flc_word_delta_decoder_unit import fwd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  fwd_in_t     in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output fwd_out_t    out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fwd_cfg_t cfg_r;
  logic     out_valid_r;
  fwd_out_t out_item_r;
  logic     skid_valid_r;
  fwd_out_t skid_item_r;
  logic     step;
  logic     res_valid;
  fwd_out_t res_item;
  logic     new_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign step      = in_valid && in_ready;
  assign new_res   = step && res_valid;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  fwd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_origin   <= 16'd0;
      cfg_r.y_origin   <= 16'd0;
      cfg_r.line_width <= 16'd320;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_ORIGIN:   cfg_r.x_origin   <= cfg_data;
        CFG_Y_ORIGIN:   cfg_r.y_origin   <= cfg_data;
        CFG_LINE_WIDTH: cfg_r.line_width <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= new_res;
      end
    end else if (new_res) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_item_r <= skid_item_r;
      end else if (new_res) begin
        out_item_r <= res_item;
      end
    end else if (new_res) begin
      skid_item_r <= res_item;
    end
  end

  // The skid register only ever fills behind a held output write.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full with output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid register did not move to the output");

  a_stall_catch: assert property (@(posedge clk) disable iff (!rst_n)
    (new_res && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("write produced during a stall was lost");

endmodule
